/* hdl/cic_pkg.sv */
// ----------------------------------------------------------------------------
// cic_pkg
// Shared types and constants for the compass iron calibrator.
// ----------------------------------------------------------------------------
package cic_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 16;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int NUM_W    = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CORRECT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_CORRECTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DONE_ZERO = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    localparam logic [SCALE_W-1:0] SCALE_CAP = 16'hFFFF;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
    } req_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_x;
        logic signed [SAMPLE_W-1:0] out_y;
        logic signed [SAMPLE_W-1:0] out_z;
        logic [STATUS_W-1:0]        status;
    } rsp_item_t;

    // per-cycle commands from the sequencer to every axis lane
    typedef struct packed {
        logic start;
        logic take;
        logic pass_two;
        logic close_hard;
        logic close_soft;
        logic div_step;
        logic finish;
    } lane_ctrl_t;

endpackage

/* hdl/cic_lane.sv */
// ----------------------------------------------------------------------------
// cic_lane
// One magnetometer axis: correction multiply, min/max tracking, hard offset
// and a bit-serial divider for the soft iron scale.
// ----------------------------------------------------------------------------
module cic_lane #(
    parameter int SCALE_FRAC_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cic_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [cic_pkg::SAMPLE_W-1:0]  sample,
    input  logic [cic_pkg::SAMPLE_W+3:0]         span_sum,
    output logic signed [cic_pkg::SAMPLE_W-1:0]  corr,
    output logic [cic_pkg::SAMPLE_W+1:0]         span,
    output logic                                 zero
);

    localparam int SW     = cic_pkg::SAMPLE_W;
    localparam int DIF_W  = SW + 2;
    localparam int SUM_W  = SW + 4;
    localparam int N_W    = SUM_W + SCALE_FRAC_BITS + 2;
    localparam int DEN_W  = DIF_W + 3;
    localparam int PROD_W = DIF_W + cic_pkg::SCALE_W + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam int ONE_I  = (SCALE_FRAC_BITS >= cic_pkg::SCALE_W) ?
                            ((1 << cic_pkg::SCALE_W) - 1) : (1 << SCALE_FRAC_BITS);
    localparam logic [cic_pkg::SCALE_W-1:0] SCALE_ONE = cic_pkg::SCALE_W'(ONE_I);
    localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (SCALE_FRAC_BITS - 1);

    logic signed [DIF_W-1:0] off_reg, off_next;
    logic signed [DIF_W-1:0] min_reg, min_next;
    logic signed [DIF_W-1:0] max_reg, max_next;
    logic [cic_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic             zero_reg, zero_next;

    logic signed [DIF_W-1:0]   s_ext;
    logic signed [DIF_W-1:0]   diff;
    logic signed [DIF_W-1:0]   v;
    logic signed [DIF_W-1:0]   nmax;
    logic signed [DIF_W-1:0]   nmin;
    logic signed [DIF_W:0]     mid;
    logic signed [PROD_W-1:0]  prod;
    logic signed [RND_W-1:0]   rnd;
    logic signed [RND_W-1:0]   shifted;
    logic [DIF_W-1:0]          d;
    logic [N_W-1:0]            num;
    logic [DEN_W:0]            rem_sh;
    logic [DEN_W:0]            trial;

    assign s_ext = $signed({{(DIF_W-SW){sample[SW-1]}}, sample});
    assign diff  = s_ext - off_reg;

    // correction: multiply, round half up, saturate
    assign prod    = diff * $signed({1'b0, scale_reg});
    assign rnd     = RND_W'(prod) + HALF;
    assign shifted = rnd >>> SCALE_FRAC_BITS;

    always_comb
    begin
        if (shifted[RND_W-1:SW-1] == '0 || shifted[RND_W-1:SW-1] == '1)
        begin
            corr = shifted[SW-1:0];
        end
        else if (shifted[RND_W-1])
        begin
            corr = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            corr = {1'b0, {(SW-1){1'b1}}};
        end
    end

    assign v    = ctrl.pass_two ? diff : s_ext;
    assign nmax = (v > max_reg) ? v : max_reg;
    assign nmin = (v < min_reg) ? v : min_reg;
    assign mid  = ($signed({nmax[DIF_W-1], nmax}) + $signed({nmin[DIF_W-1], nmin})) >>> 1;
    assign d    = DIF_W'(nmax - nmin);
    assign span = d;
    assign zero = zero_reg;

    assign num = (N_W'(span_sum) << (SCALE_FRAC_BITS + 1)) + N_W'(d) + (N_W'(d) << 1);

    assign rem_sh = {rem_reg, quo_reg[N_W-1]};
    assign trial  = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        off_next   = off_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        scale_next = scale_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        zero_next  = zero_reg;
        if (ctrl.start)
        begin
            off_next   = '0;
            scale_next = SCALE_ONE;
            min_next   = '0;
            max_next   = '0;
        end
        else if (ctrl.take)
        begin
            min_next = nmin;
            max_next = nmax;
            if (ctrl.close_hard)
            begin
                off_next = mid[DIF_W-1:0];
                min_next = '0;
                max_next = '0;
            end
            else if (ctrl.close_soft)
            begin
                min_next  = '0;
                max_next  = '0;
                quo_next  = num;
                rem_next  = '0;
                den_next  = (DEN_W'(d) << 1) + (DEN_W'(d) << 2);
                zero_next = (d == '0);
            end
        end
        else if (ctrl.div_step)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
        end
        else if (ctrl.finish)
        begin
            // a zero span divides to all ones and lands on the cap as well
            if (quo_reg[N_W-1:cic_pkg::SCALE_W] != '0)
            begin
                scale_next = cic_pkg::SCALE_CAP;
            end
            else
            begin
                scale_next = quo_reg[cic_pkg::SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            scale_reg <= SCALE_ONE;
            zero_reg  <= 1'b0;
        end
        else
        begin
            off_reg   <= off_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            scale_reg <= scale_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

/* hdl/compass_iron_calibrator.sv */
// ----------------------------------------------------------------------------
// compass_iron_calibrator
// Hard and soft iron correction with min/max calibration, three axis lanes.
// ----------------------------------------------------------------------------
//  channel  | valid      | stall      | payload   | dir
//  request  | req_valid  | req_stall  | req       | in
//  response | rsp_valid  | rsp_stall  | rsp       | out
//  config   | cfg_wen    | -          | cfg_wdata | in
//
// correct, start and calibration sample items pass through the idle and calc states.
// the item that closes pass two also runs the divide and finish states: the three
// lane dividers run one quotient bit per cycle over SCALE_FRAC_BITS + 22 bits.
// a new item is taken while the previous result waits in the output register.
// reset is asynchronous; scales come up at one, offsets at zero.
module compass_iron_calibrator #(
    parameter int SCALE_FRAC_BITS = 12,
    parameter int COUNT_WIDTH     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  cic_pkg::req_item_t            req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output cic_pkg::rsp_item_t            rsp,
    input  logic                          cfg_wen,
    input  logic [cic_pkg::NUM_W-1:0]     cfg_wdata
);

    localparam int SW     = cic_pkg::SAMPLE_W;
    localparam int N_W    = SW + 4 + SCALE_FRAC_BITS + 2;
    localparam int DC_W   = $clog2(N_W);
    localparam int LW     = ((COUNT_WIDTH > cic_pkg::NUM_W) ? COUNT_WIDTH : cic_pkg::NUM_W) + 1;
    localparam int CMAX_I = (1 << COUNT_WIDTH) - 1;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_FIN} state_t;
    typedef enum logic [1:0] {PH_IDLE, PH_HARD, PH_SOFT} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]    cnt_reg, cnt_next;
    logic [DC_W-1:0]           div_cnt_reg, div_cnt_next;
    logic [cic_pkg::NUM_W-1:0] num_reg;
    cic_pkg::req_item_t        req_reg;
    logic                      rsp_valid_reg, rsp_valid_next;
    cic_pkg::rsp_item_t        rsp_reg, rsp_next;

    cic_pkg::lane_ctrl_t       ctrl;
    logic signed [SW-1:0]      corr [3];
    logic [SW+1:0]             span [3];
    logic                      zero [3];
    logic [SW+3:0]             span_sum;
    logic signed [SW-1:0]      lane_sample [3];
    logic                      out_free;
    logic [LW-1:0]             len;
    logic [LW-1:0]             cnt_inc;
    logic                      close;

    assign lane_sample[0] = req_reg.sample_x;
    assign lane_sample[1] = req_reg.sample_y;
    assign lane_sample[2] = req_reg.sample_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        cic_lane #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sample   (lane_sample[i]),
            .span_sum (span_sum),
            .corr     (corr[i]),
            .span     (span[i]),
            .zero     (zero[i])
        );
    end

    // merge: total span across the lanes
    assign span_sum = (SW+4)'(span[0]) + (SW+4)'(span[1]) + (SW+4)'(span[2]);

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (num_reg == '0)
        begin
            len = LW'(1);
        end
        else if (LW'(num_reg) > LW'(CMAX_I))
        begin
            len = LW'(CMAX_I);
        end
        else
        begin
            len = LW'(num_reg);
        end
    end

    assign cnt_inc = LW'(cnt_reg) + LW'(1);
    assign close   = (cnt_inc >= len);

    always_comb
    begin
        ctrl           = '0;
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        div_cnt_next   = div_cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ctrl.pass_two  = (phase_reg == PH_SOFT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (out_free)
                begin
                    rsp_next        = '0;
                    rsp_next.status = cic_pkg::ST_IGNORED;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                    if (req_reg.req_type == cic_pkg::REQ_CORRECT)
                    begin
                        rsp_next.out_x  = corr[0];
                        rsp_next.out_y  = corr[1];
                        rsp_next.out_z  = corr[2];
                        rsp_next.status = cic_pkg::ST_CORRECTED;
                    end
                    else if (req_reg.req_type == cic_pkg::REQ_START)
                    begin
                        ctrl.start      = 1'b1;
                        cnt_next        = '0;
                        phase_next      = PH_HARD;
                        rsp_next.status = cic_pkg::ST_TAKEN;
                    end
                    else if (req_reg.req_type == cic_pkg::REQ_SAMPLE && phase_reg != PH_IDLE)
                    begin
                        ctrl.take       = 1'b1;
                        cnt_next        = cnt_inc[COUNT_WIDTH-1:0];
                        rsp_next.status = cic_pkg::ST_TAKEN;
                        if (close)
                        begin
                            cnt_next = '0;
                            if (phase_reg == PH_HARD)
                            begin
                                ctrl.close_hard = 1'b1;
                                phase_next      = PH_SOFT;
                            end
                            else
                            begin
                                // result waits for the dividers
                                ctrl.close_soft = 1'b1;
                                phase_next      = PH_IDLE;
                                rsp_valid_next  = rsp_valid_reg && rsp_stall;
                                rsp_next        = rsp_reg;
                                div_cnt_next    = '0;
                                state_next      = S_DIV;
                            end
                        end
                    end
                end
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                div_cnt_next  = div_cnt_reg + DC_W'(1);
                if (div_cnt_reg == DC_W'(N_W - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ctrl.finish     = 1'b1;
                    rsp_next        = '0;
                    rsp_next.status = (zero[0] || zero[1] || zero[2]) ?
                                      cic_pkg::ST_DONE_ZERO : cic_pkg::ST_DONE;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            num_reg       <= cic_pkg::NUM_W'(256);
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            div_cnt_reg   <= div_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (cfg_wen)
            begin
                num_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
    end

endmodule

/* hdl/cic_checker.sv */
// ----------------------------------------------------------------------------
// cic_checker
// Port-level checks for the compass iron calibrator.
// ----------------------------------------------------------------------------
module cic_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input cic_pkg::rsp_item_t rsp
);

    // a held item keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one item at a time in the core
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while core busy");

    // axis values only on corrected items
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != cic_pkg::ST_CORRECTED |->
        rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_z == '0)
        else $error("nonzero axis on non-correct item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= cic_pkg::ST_IGNORED)
        else $error("bad status code");

endmodule

bind compass_iron_calibrator cic_checker u_cic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
